// File: hw/rtl/event_flag_group_unit_assert.svh
// ----------------------------------------------------------------------------
// Event flag group assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef EVENT_FLAG_GROUP_UNIT_ASSERT_SVH
`define EVENT_FLAG_GROUP_UNIT_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define EFGU_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// A condition that, once seen, forces another one in the next cycle.
`define EFGU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/efgu_pkg.sv
// ----------------------------------------------------------------------------
// Event flag group package
// Types and codes shared by the waiter cells and the top level.
// ----------------------------------------------------------------------------
package efgu_pkg;

   localparam logic [1:0] OP_POLL     = 2'd0;
   localparam logic [1:0] OP_NOTIFY   = 2'd1;
   localparam logic [1:0] OP_RESET    = 2'd2;
   localparam logic [1:0] OP_WITHDRAW = 2'd3;

   localparam logic [3:0] KIND_MATCHED     = 4'd0;
   localparam logic [3:0] KIND_PENDED      = 4'd1;
   localparam logic [3:0] KIND_WOULD_BLOCK = 4'd2;
   localparam logic [3:0] KIND_LIST_FULL   = 4'd3;
   localparam logic [3:0] KIND_WOKEN       = 4'd4;
   localparam logic [3:0] KIND_CANCELLED   = 4'd5;
   localparam logic [3:0] KIND_NOTIFY_DONE = 4'd6;
   localparam logic [3:0] KIND_RESET_DONE  = 4'd7;
   localparam logic [3:0] KIND_WITHDRAWN   = 4'd8;
   localparam logic [3:0] KIND_NOT_FOUND   = 4'd9;

   typedef struct packed {
      logic [3:0] tid;
      logic [7:0] wmask;
      logic       cons;
   } waiter_type;

   // Movement of the waiter chain in one cycle.
   typedef struct packed {
      logic append;
      logic shift;
      logic rotate;
   } chain_ctl_type;

   typedef struct packed {
      logic [3:0] kind;
      logic [3:0] tid;
      logic [7:0] bits;
      logic [3:0] count;
      logic       yield_req;
   } result_type;

endpackage

// File: hw/rtl/efgu_cell.sv
// ----------------------------------------------------------------------------
// Waiter cell
// Holds one waiter; loads a new entry, takes its neighbor, or takes the head.
// ----------------------------------------------------------------------------
module efgu_cell (
   input  logic                   clock,
   input  efgu_pkg::chain_ctl_type ctl,
   input  logic                   is_free,
   input  logic                   is_tail,
   input  efgu_pkg::waiter_type   new_entry,
   input  efgu_pkg::waiter_type   next_entry,
   input  efgu_pkg::waiter_type   head_entry,
   output efgu_pkg::waiter_type   entry
);

   efgu_pkg::waiter_type entry_ff;
   efgu_pkg::waiter_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.append && is_free) begin
         entry_in = new_entry;
      end else if (ctl.shift) begin
         entry_in = next_entry;
      end else if (ctl.rotate) begin
         entry_in = is_tail ? head_entry : next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// File: hw/rtl/event_flag_group_unit.sv
// ----------------------------------------------------------------------------
// Event flag group unit
// Flag word plus an ordered chain of waiting threads, driven by kernel calls.
// ----------------------------------------------------------------------------
// Usage: a command beat enters on the req_ channel (valid/stall) and produces
// one or more result beats on the rsp_ channel; the final one carries rsp_last.
// The block takes one command at a time: req_stall stays high from the cycle
// after a beat is taken until all results of that command are handed to the
// output register. Notify and withdraw walk the waiter chain one cell per
// cycle; a group reset cancels the waiters one at a time from the head
// before it is done. The walk rotates the chain through its head cell, so
// its length is set by the number of queued waiters, at most WAITER_SLOTS.
// Results are collected in a small buffer first, since every result carries
// the flag word as it stands after the whole command. A stalled rsp_ beat
// holds its payload; the next result waits behind it.
// The csr_ channel writes the flag reset value and is always ready; the user
// must write it only while the block is idle; the block does not enforce it.
// Reset empties the chain, clears the flag reset value and zeroes the flag word.
// ----------------------------------------------------------------------------
module event_flag_group_unit #(
   parameter int WAITER_SLOTS = 8,
   parameter int THREAD_IDS   = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_opcode,
   input  logic [3:0] req_thread_id,
   input  logic [7:0] req_mask,
   input  logic       req_consume,
   input  logic       req_sched,
   input  logic       req_no_wait,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_kind,
   output logic [3:0] rsp_thread_id_out,
   output logic [7:0] rsp_bits,
   output logic [3:0] rsp_count,
   output logic       rsp_yield_request,
   output logic [7:0] rsp_flag_word_now,
   output logic       rsp_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);

`include "event_flag_group_unit_assert.svh"

   localparam int CNT_W     = $clog2(WAITER_SLOTS + 1);
   localparam int BUF_DEPTH = WAITER_SLOTS + 1;
   localparam int PTR_W     = $clog2(BUF_DEPTH + 1);
   localparam int IDX_W     = $clog2(BUF_DEPTH);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_WALK   = 2'd1;
   localparam logic [1:0] ST_CANCEL = 2'd2;
   localparam logic [1:0] ST_EMIT   = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [7:0]       flag_ff, flag_in;
   logic [7:0]       rst_val_ff, rst_val_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [7:0]       nv_ff, nv_in;
   logic             done_ff, done_in;
   logic [3:0]       woken_ff, woken_in;
   logic [1:0]       op_ff, op_in;
   logic [3:0]       tid_ff, tid_in;
   logic             sched_ff, sched_in;
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic             rsp_valid_ff, rsp_valid_in;
   efgu_pkg::result_type rsp_rec_ff, rsp_rec_in;
   logic [7:0]       rsp_flag_ff, rsp_flag_in;
   logic             rsp_last_ff, rsp_last_in;

   efgu_pkg::result_type buf_ff [BUF_DEPTH];
   logic                 push;
   efgu_pkg::result_type push_rec;

   efgu_pkg::chain_ctl_type ctl;
   efgu_pkg::waiter_type    new_entry;
   efgu_pkg::waiter_type    cells [WAITER_SLOTS];
   efgu_pkg::waiter_type    head;

   logic [3:0] tid_mod;
   logic [7:0] trig;
   logic [7:0] nv_next;
   logic       hit;
   logic       load;

   // Thread ids wrap at THREAD_IDS; the input is narrow, so a constant table does it.
   always_comb begin
      tid_mod = '0;
      for (int i = 0; i < 16; i++) begin
         if (req_thread_id == 4'(i)) begin
            tid_mod = 4'(i % THREAD_IDS);
         end
      end
   end

   // The chain of waiter cells; cell 0 is the oldest waiter.
   genvar k;
   generate
      for (k = 0; k < WAITER_SLOTS; k++) begin : g_cell
         efgu_pkg::waiter_type nxt;
         if (k == WAITER_SLOTS - 1) begin : g_end
            assign nxt = '0;
         end else begin : g_mid
            assign nxt = cells[k+1];
         end
         efgu_cell u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .is_free    (cnt_ff == CNT_W'(k)),
            .is_tail    (cnt_ff == CNT_W'(k + 1)),
            .new_entry  (new_entry),
            .next_entry (nxt),
            .head_entry (head),
            .entry      (cells[k])
         );
      end
   endgenerate

   assign head      = cells[0];
   assign new_entry = '{tid: tid_mod, wmask: req_mask, cons: req_consume};

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign load      = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      flag_in      = flag_ff;
      rst_val_in   = rst_val_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      nv_in        = nv_ff;
      done_in      = done_ff;
      woken_in     = woken_ff;
      op_in        = op_ff;
      tid_in       = tid_ff;
      sched_in     = sched_ff;
      wr_in        = wr_ff;
      rd_in        = rd_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_rec_in   = rsp_rec_ff;
      rsp_flag_in  = rsp_flag_ff;
      rsp_last_in  = rsp_last_ff;
      push         = 1'b0;
      push_rec     = '0;
      ctl          = '0;
      trig         = '0;
      nv_next      = nv_ff;
      hit          = 1'b0;

      if (csr_valid) begin
         rst_val_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_opcode;
               tid_in   = tid_mod;
               sched_in = req_sched;
               woken_in = '0;
               rem_in   = cnt_ff;
               trig     = flag_ff & req_mask;
               unique case (req_opcode)
                  efgu_pkg::OP_POLL: begin
                     push          = 1'b1;
                     push_rec.tid  = tid_mod;
                     state_in      = ST_EMIT;
                     priority if (req_mask == 8'd0) begin
                        push_rec.kind = efgu_pkg::KIND_MATCHED;
                     end else if (trig != 8'd0) begin
                        push_rec.kind = efgu_pkg::KIND_MATCHED;
                        push_rec.bits = trig;
                        if (req_consume) begin
                           flag_in = flag_ff & ~req_mask;
                        end
                     end else if (req_no_wait) begin
                        push_rec.kind = efgu_pkg::KIND_WOULD_BLOCK;
                     end else if (cnt_ff >= CNT_W'(WAITER_SLOTS)) begin
                        push_rec.kind = efgu_pkg::KIND_LIST_FULL;
                     end else begin
                        push_rec.kind = efgu_pkg::KIND_PENDED;
                        ctl.append    = 1'b1;
                        cnt_in        = cnt_ff + 1'b1;
                     end
                  end
                  efgu_pkg::OP_NOTIFY: begin
                     nv_in    = req_mask & ~flag_ff;
                     done_in  = ((req_mask & ~flag_ff) == 8'd0);
                     state_in = ST_WALK;
                  end
                  efgu_pkg::OP_RESET: begin
                     state_in = ST_CANCEL;
                  end
                  efgu_pkg::OP_WITHDRAW: begin
                     done_in  = 1'b0;
                     state_in = ST_WALK;
                  end
               endcase
            end
         end

         // One head cell per cycle: a hit leaves the chain, a miss goes to the
         // tail. Once the search is over the rest rotate through to keep order.
         ST_WALK: begin
            if (rem_ff == '0) begin
               push         = 1'b1;
               push_rec.tid = tid_ff;
               if (op_ff == efgu_pkg::OP_NOTIFY) begin
                  flag_in            = flag_ff | nv_ff;
                  push_rec.kind      = efgu_pkg::KIND_NOTIFY_DONE;
                  push_rec.count     = woken_ff;
                  push_rec.yield_req = (woken_ff != 4'd0) && sched_ff;
               end else begin
                  push_rec.kind = done_ff ? efgu_pkg::KIND_WITHDRAWN
                                          : efgu_pkg::KIND_NOT_FOUND;
               end
               state_in = ST_EMIT;
            end else begin
               trig = nv_ff & head.wmask;
               hit  = (op_ff == efgu_pkg::OP_NOTIFY) ? (trig != 8'd0)
                                                     : (head.tid == tid_ff);
               rem_in = rem_ff - 1'b1;
               if (!done_ff && hit) begin
                  ctl.shift = 1'b1;
                  cnt_in    = cnt_ff - 1'b1;
                  if (op_ff == efgu_pkg::OP_NOTIFY) begin
                     woken_in       = woken_ff + 1'b1;
                     push           = 1'b1;
                     push_rec.kind  = efgu_pkg::KIND_WOKEN;
                     push_rec.tid   = head.tid;
                     push_rec.bits  = trig;
                     push_rec.count = woken_ff + 1'b1;
                     nv_next        = head.cons ? (nv_ff & ~trig) : nv_ff;
                     nv_in          = nv_next;
                     done_in        = (nv_next == 8'd0);
                  end else begin
                     done_in = 1'b1;
                  end
               end else begin
                  ctl.rotate = 1'b1;
               end
            end
         end

         ST_CANCEL: begin
            push = 1'b1;
            if (cnt_ff == '0) begin
               flag_in        = rst_val_ff;
               push_rec.kind  = efgu_pkg::KIND_RESET_DONE;
               push_rec.tid   = tid_ff;
               push_rec.count = woken_ff;
               state_in       = ST_EMIT;
            end else begin
               ctl.shift      = 1'b1;
               cnt_in         = cnt_ff - 1'b1;
               woken_in       = woken_ff + 1'b1;
               push_rec.kind  = efgu_pkg::KIND_CANCELLED;
               push_rec.tid   = head.tid;
               push_rec.count = woken_ff + 1'b1;
            end
         end

         ST_EMIT: begin
            if (rd_ff == wr_ff) begin
               rd_in    = '0;
               wr_in    = '0;
               state_in = ST_IDLE;
            end else if (load) begin
               rsp_valid_in = 1'b1;
               rsp_rec_in   = buf_ff[rd_ff[IDX_W-1:0]];
               rsp_flag_in  = flag_ff;
               rsp_last_in  = (rd_ff + 1'b1 == wr_ff);
               rd_in        = rd_ff + 1'b1;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (push) begin
         wr_in = wr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         flag_ff      <= '0;
         rst_val_ff   <= '0;
         cnt_ff       <= '0;
         rem_ff       <= '0;
         done_ff      <= 1'b0;
         woken_ff     <= '0;
         wr_ff        <= '0;
         rd_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         flag_ff      <= flag_in;
         rst_val_ff   <= rst_val_in;
         cnt_ff       <= cnt_in;
         rem_ff       <= rem_in;
         done_ff      <= done_in;
         woken_ff     <= woken_in;
         wr_ff        <= wr_in;
         rd_ff        <= rd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nv_ff       <= nv_in;
      op_ff       <= op_in;
      tid_ff      <= tid_in;
      sched_ff    <= sched_in;
      rsp_rec_ff  <= rsp_rec_in;
      rsp_flag_ff <= rsp_flag_in;
      rsp_last_ff <= rsp_last_in;
      if (push) begin
         buf_ff[wr_ff[IDX_W-1:0]] <= push_rec;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_rec_ff.kind;
   assign rsp_thread_id_out = rsp_rec_ff.tid;
   assign rsp_bits          = rsp_rec_ff.bits;
   assign rsp_count         = rsp_rec_ff.count;
   assign rsp_yield_request = rsp_rec_ff.yield_req;
   assign rsp_flag_word_now = rsp_flag_ff;
   assign rsp_last          = rsp_last_ff;

   `EFGU_ASSERT_ALWAYS(a_cnt_bound, cnt_ff <= CNT_W'(WAITER_SLOTS), "waiter count overflow")
   `EFGU_ASSERT_ALWAYS(a_walk_rem, (state_ff != ST_WALK) || (rem_ff <= cnt_ff),
      "walk has more cells left than waiters")
   `EFGU_ASSERT_NEXT(a_accept_busy, req_valid && !req_stall, state_ff != ST_IDLE,
      "accepted command did not start")

endmodule
